@@ design/pml_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pml_pkg;

    // number of sample lanes carried by one input word
    localparam int LANES = 4;
    localparam int SAMPLE_W = 16;
    localparam int MASK_W = 4;
    // sum of four int16 samples, and its magnitude
    localparam int SUM_W = 18;
    localparam int MAG_W = 18;

    localparam logic [MAG_W-1:0] PCM_MAX = MAG_W'(32767);
    localparam logic [MAG_W-1:0] PCM_MIN_MAG = MAG_W'(32768);
    localparam logic [SAMPLE_W-1:0] PCM_MAX_CODE = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] PCM_MIN_CODE = 16'h8000;
    localparam int RECOVER_SHIFT = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_DIV,
        ST_RECOVER,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic eval;
        logic div_step;
        logic recover;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clip_now;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ design/pml_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pml_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire pml_pkg::status_t status,
    output pml_pkg::cmd_t         cmd
);

    pml_pkg::state_t state_reg;
    pml_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pml_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pml_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = pml_pkg::ST_MUL;
                end
            end
            pml_pkg::ST_MUL:
            begin
                state_next = pml_pkg::ST_EVAL;
            end
            pml_pkg::ST_EVAL:
            begin
                state_next = status.clip_now ? pml_pkg::ST_DIV : pml_pkg::ST_RECOVER;
            end
            pml_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = pml_pkg::ST_RECOVER;
                end
            end
            pml_pkg::ST_RECOVER:
            begin
                state_next = pml_pkg::ST_HOLD;
            end
            pml_pkg::ST_HOLD:
            begin
                if (status.out_free)
                begin
                    state_next = pml_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pml_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            pml_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.load_in = s_axis_tvalid;
            end
            pml_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            pml_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            pml_pkg::ST_DIV:
            begin
                cmd.div_step = !status.div_done;
            end
            pml_pkg::ST_RECOVER:
            begin
                cmd.recover = 1'b1;
            end
            pml_pkg::ST_HOLD:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/pml_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pml_datapath #(
    parameter int SOURCES = 4,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire pml_pkg::cmd_t                             cmd,
    output pml_pkg::status_t                               status,
    input  wire logic [pml_pkg::LANES*pml_pkg::SAMPLE_W-1:0] in_samples,
    input  wire logic [pml_pkg::MASK_W-1:0]                present_mask,
    input  wire logic                                      buffer_start,
    output logic [pml_pkg::SAMPLE_W-1:0]                   mixed_sample,
    output logic                                           clipped,
    output logic                                           out_valid,
    input  wire logic                                      out_ready
);

    localparam int GAIN_W = GAIN_FRAC_BITS + 1;
    localparam int PROD_W = pml_pkg::MAG_W + GAIN_W;
    localparam int CNT_W = $clog2(GAIN_FRAC_BITS + 1);
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;

    logic [GAIN_W-1:0]             gain_reg;
    logic                          neg_reg;
    logic [pml_pkg::MAG_W-1:0]     mag_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic                          clip_reg;
    logic [pml_pkg::SAMPLE_W-1:0]  res_reg;
    logic [pml_pkg::MAG_W-1:0]     rem_reg;
    logic [pml_pkg::MAG_W-1:0]     divisor_reg;
    logic [GAIN_W-1:0]             quot_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          out_valid_reg;
    logic [pml_pkg::SAMPLE_W-1:0]  out_sample_reg;
    logic                          out_clip_reg;

    logic signed [pml_pkg::SUM_W-1:0] sum;
    logic [pml_pkg::MAG_W-1:0]     scaled;
    logic                          clip_hi;
    logic                          clip_lo;
    logic [pml_pkg::SAMPLE_W-1:0]  scaled_code;
    logic [pml_pkg::MAG_W:0]       rem_shift;
    logic                          rem_ge;
    logic [GAIN_W-1:0]             gain_src;
    logic [GAIN_W-1:0]             gain_gap;

    // sum of present lanes, lanes at or beyond SOURCES are ignored
    always_comb
    begin
        sum = '0;
        for (int k = 0; k < pml_pkg::LANES; k++)
        begin
            if (k < SOURCES && present_mask[k])
            begin
                sum = sum + pml_pkg::SUM_W'(
                    $signed(in_samples[k*pml_pkg::SAMPLE_W +: pml_pkg::SAMPLE_W]));
            end
        end
    end

    assign scaled = prod_reg[GAIN_FRAC_BITS +: pml_pkg::MAG_W];
    assign clip_hi = !neg_reg && (scaled > pml_pkg::PCM_MAX);
    assign clip_lo = neg_reg && (scaled > pml_pkg::PCM_MIN_MAG);
    assign scaled_code = neg_reg ? pml_pkg::SAMPLE_W'(-scaled) : scaled[pml_pkg::SAMPLE_W-1:0];

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge = rem_shift >= {1'b0, divisor_reg};

    assign gain_src = clip_reg ? quot_reg : gain_reg;
    assign gain_gap = GAIN_ONE - gain_src;

    assign status.clip_now = clip_hi || clip_lo;
    assign status.div_done = (cnt_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;

    // payload and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            neg_reg <= sum[pml_pkg::SUM_W-1];
            mag_reg <= sum[pml_pkg::SUM_W-1] ? pml_pkg::MAG_W'(-sum) : pml_pkg::MAG_W'(sum);
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(gain_reg);
        end
        if (cmd.eval)
        begin
            clip_reg <= clip_hi || clip_lo;
            // quotient has no integer bits, so the remainder starts at the limit
            rem_reg <= clip_lo ? pml_pkg::PCM_MIN_MAG : pml_pkg::PCM_MAX;
            divisor_reg <= scaled;
            quot_reg <= '0;
            priority if (clip_hi)
            begin
                res_reg <= pml_pkg::PCM_MAX_CODE;
            end
            else if (clip_lo)
            begin
                res_reg <= pml_pkg::PCM_MIN_CODE;
            end
            else
            begin
                res_reg <= scaled_code;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? pml_pkg::MAG_W'(rem_shift - {1'b0, divisor_reg})
                              : rem_shift[pml_pkg::MAG_W-1:0];
            quot_reg <= {quot_reg[GAIN_W-2:0], rem_ge};
        end
        if (cmd.load_out)
        begin
            out_sample_reg <= res_reg;
            out_clip_reg <= clip_reg;
        end
    end

    // control state: gain, divide counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_ONE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in && buffer_start)
            begin
                gain_reg <= GAIN_ONE;
            end
            else if (cmd.recover)
            begin
                if (gain_src < GAIN_ONE)
                begin
                    gain_reg <= gain_src + (gain_gap >> pml_pkg::RECOVER_SHIFT);
                end
                else
                begin
                    gain_reg <= gain_src;
                end
            end
            if (cmd.eval)
            begin
                cnt_reg <= CNT_W'(GAIN_FRAC_BITS);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign mixed_sample = out_sample_reg;
    assign clipped = out_clip_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ design/pcm_mixer_adaptive_limiter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel    dir  handshake                      payload
// s_axis     in   s_axis_tvalid / s_axis_tready  tdata: four samples, tuser: mask, buffer start
// m_axis     out  m_axis_tvalid / m_axis_tready  tdata: mixed sample, tuser: clipped
//
// one word steps through accept, multiply, evaluate, recover and hand over; a clipped word
// also runs the shift-subtract divider for the new gain between evaluate and recover
// asynchronous active-low reset returns the gain to unity and empties the output
// the result sits in an output register, so the next word is accepted while it waits
// a finished word that finds the output register still full waits until it drains

module pcm_mixer_adaptive_limiter #(
    parameter int SOURCES = 4,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // sample_a [15:0], sample_b [31:16], sample_c [47:32], sample_d [63:48]
    input  wire logic [63:0] s_axis_tdata,
    // present_mask [3:0], buffer_start [4], zero [7:5]
    input  wire logic [7:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // mixed_sample [15:0]
    output logic [15:0]      m_axis_tdata,
    // clipped [0], zero [7:1]
    output logic [7:0]       m_axis_tuser
);

    pml_pkg::cmd_t    cmd;
    pml_pkg::status_t status;
    logic             clipped;

    // sequencer: accept, multiply, evaluate, divide, recover, hand over
    pml_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // sum, gain multiply, clip, gain divide and recovery
    pml_datapath #(
        .SOURCES        (SOURCES),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_samples    (s_axis_tdata),
        .present_mask  (s_axis_tuser[3:0]),
        .buffer_start  (s_axis_tuser[4]),
        .mixed_sample  (m_axis_tdata),
        .clipped       (clipped),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready)
    );

    assign m_axis_tuser = {7'b0, clipped};

endmodule

`default_nettype wire
